// ===== rtl/romcd_pkg.sv =====
// Shared types and constants for the ROM emulator command decoder.
package romcd_pkg;

  localparam int unsigned WORD_ADDR_BITS  = 18;
  localparam int unsigned MAX_BURST_WORDS = 16;

  localparam int unsigned AddrFieldW = 18;
  localparam int unsigned WinW       = 10;
  localparam int unsigned BurstW     = $clog2(MAX_BURST_WORDS + 1);

  localparam logic [7:0] OpcNop    = 8'h01 - 8'h01;
  localparam logic [7:0] OpcClear  = 8'h01;
  localparam logic [7:0] OpcLedOn  = 8'h55;
  localparam logic [7:0] OpcLedOff = 8'hAA;
  localparam logic [3:0] GrpMode   = 4'h1;
  localparam logic [3:0] GrpBurst  = 4'h2;
  localparam logic [3:0] GrpWin    = 4'h4;

  localparam logic [1:0] ModeRun = 2'd1;

  // Opcode class of a host byte, valid when it arrives in the idle phase.
  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_CLEAR,
    OP_MODE,
    OP_BURST,
    OP_WIN,
    OP_LED_ON,
    OP_LED_OFF
  } op_e;

  typedef struct packed {
    logic                  is_read;
    op_e                   op;
    logic [7:0]            data;
    logic [AddrFieldW-1:0] addr;
  } item_t;

  typedef struct packed {
    logic                  mem_write_valid;
    logic [AddrFieldW-1:0] mem_word_addr;
    logic [15:0]           mem_word;
    logic                  exfil_valid;
    logic [7:0]            exfil_byte;
    logic [1:0]            mode_now;
    logic                  exfil_on;
    logic                  led_on;
  } res_t;

endpackage

// ===== rtl/romcd_front.sv =====
// Front end: takes requests and classifies host bytes by opcode.
module romcd_front
  import romcd_pkg::*;
(
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [7:0]            host_byte_i,
  input  logic [AddrFieldW-1:0] target_addr_i,
  output logic                  push_o,
  output item_t                 item_o,
  input  logic                  full_i
);

  op_e op;

  always_comb begin
    priority if (host_byte_i == OpcNop) begin
      op = OP_IGNORE;
    end else if (host_byte_i == OpcClear) begin
      op = OP_CLEAR;
    end else if (host_byte_i == OpcLedOn) begin
      op = OP_LED_ON;
    end else if (host_byte_i == OpcLedOff) begin
      op = OP_LED_OFF;
    end else if (host_byte_i[7:4] == GrpMode) begin
      op = OP_MODE;
    end else if (host_byte_i[7:4] == GrpBurst) begin
      op = OP_BURST;
    end else if (host_byte_i[7:4] == GrpWin) begin
      op = OP_WIN;
    end else begin
      op = OP_IGNORE;
    end
  end

  assign in_stall_o     = full_i;
  assign push_o         = in_valid_i && !full_i;
  assign item_o.is_read = command_i;
  assign item_o.op      = op;
  assign item_o.data    = host_byte_i;
  assign item_o.addr    = target_addr_i;

endmodule

// ===== rtl/romcd_fifo.sv =====
// Two-entry request queue between front and back.
module romcd_fifo
  import romcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/romcd_back.sv =====
// Back end: parses commands, updates decoder state and holds the result register.
module romcd_back
  import romcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_WIN
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [BurstW-1:0]         left_q, left_d;
  logic [7:0]                high_q, high_d;
  logic [1:0]                win_hi_q, win_hi_d;
  logic [WORD_ADDR_BITS-1:0] ctr_q, ctr_d;
  logic [1:0]                mode_q, mode_d;
  logic                      exen_q, exen_d;
  logic [WinW-1:0]           win_q, win_d;
  logic                      led_q, led_d;
  logic                      out_valid_q, out_valid_d;
  res_t                      res_q, res_d;
  logic [BurstW-1:0]         left_dec;
  logic                      hit;

  assign pop_o       = valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign left_dec    = left_q - BurstW'(1);
  assign hit = (mode_q == ModeRun) && exen_q &&
               (item_i.addr[AddrFieldW-1:8] == win_q);

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    high_d      = high_q;
    win_hi_d    = win_hi_q;
    ctr_d       = ctr_q;
    mode_d      = mode_q;
    exen_d      = exen_q;
    win_d       = win_q;
    led_d       = led_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      out_valid_d           = 1'b1;
      res_d.mem_write_valid = 1'b0;
      res_d.mem_word_addr   = '0;
      res_d.mem_word        = '0;
      res_d.exfil_valid     = 1'b0;
      res_d.exfil_byte      = '0;
      if (item_i.is_read) begin
        if (hit) begin
          res_d.exfil_valid = 1'b1;
          res_d.exfil_byte  = item_i.addr[7:0];
        end
      end else begin
        unique case (phase_q)
          PH_HIGH: begin
            high_d  = item_i.data;
            phase_d = PH_LOW;
          end
          PH_LOW: begin
            res_d.mem_write_valid = 1'b1;
            res_d.mem_word_addr   = AddrFieldW'(ctr_q);
            res_d.mem_word        = {high_q, item_i.data};
            ctr_d                 = ctr_q + WORD_ADDR_BITS'(1);
            left_d                = left_dec;
            phase_d               = (left_dec == '0) ? PH_IDLE : PH_HIGH;
          end
          PH_WIN: begin
            win_d   = {win_hi_q, item_i.data};
            phase_d = PH_IDLE;
          end
          default: begin
            unique case (item_i.op)
              OP_CLEAR:   ctr_d = '0;
              OP_LED_ON:  led_d = 1'b1;
              OP_LED_OFF: led_d = 1'b0;
              OP_MODE: begin
                mode_d = item_i.data[1:0];
                exen_d = item_i.data[2];
              end
              OP_BURST: begin
                left_d  = (item_i.data[3:0] == 4'd0) ? BurstW'(MAX_BURST_WORDS)
                                                      : BurstW'(item_i.data[3:0]);
                phase_d = PH_HIGH;
              end
              OP_WIN: begin
                win_hi_d = item_i.data[1:0];
                phase_d  = PH_WIN;
              end
              default: ;
            endcase
          end
        endcase
      end
      res_d.mode_now = mode_d;
      res_d.exfil_on = exen_d;
      res_d.led_on   = led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      left_q      <= '0;
      high_q      <= '0;
      win_hi_q    <= '0;
      ctr_q       <= '0;
      mode_q      <= '0;
      exen_q      <= 1'b0;
      win_q       <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      high_q      <= high_d;
      win_hi_q    <= win_hi_d;
      ctr_q       <= ctr_d;
      mode_q      <= mode_d;
      exen_q      <= exen_d;
      win_q       <= win_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  a_burst_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HIGH || phase_q == PH_LOW) |-> left_q != '0)
    else $error("burst phase with no words left");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped request did not reach the result register");

  a_exfil_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.exfil_valid) |-> (res_q.mode_now == ModeRun && res_q.exfil_on))
    else $error("exfiltration outside run mode");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.exfil_valid && res_q.mem_write_valid))
    else $error("write and exfiltration in one result");

endmodule

// ===== rtl/rom_emulator_command_decoder.sv =====
// ROM emulator command decoder: front classifier, request queue and back executor.
// An accepted request goes into the queue, then is popped into the result register.
// Throughput: one request per cycle while out_stall_i is low; the two-entry queue
// and the result register let front and back stall independently, so in_stall_o
// rises only when the queue is full.
// Reset (rst_ni low, asynchronous): parser idle, all decoder state cleared, queue empty.
module rom_emulator_command_decoder
  import romcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [7:0]            host_byte_i,
  input  logic [AddrFieldW-1:0] target_addr_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  mem_write_valid_o,
  output logic [AddrFieldW-1:0] mem_word_addr_o,
  output logic [15:0]           mem_word_o,
  output logic                  exfil_valid_o,
  output logic [7:0]            exfil_byte_o,
  output logic [1:0]            mode_now_o,
  output logic                  exfil_on_o,
  output logic                  led_on_o
);

  logic  push, full, q_valid, pop;
  item_t push_item, q_item;
  res_t  res;

  romcd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .host_byte_i  (host_byte_i),
    .target_addr_i(target_addr_i),
    .push_o       (push),
    .item_o       (push_item),
    .full_i       (full)
  );

  romcd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  romcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (q_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign mem_write_valid_o = res.mem_write_valid;
  assign mem_word_addr_o   = res.mem_word_addr;
  assign mem_word_o        = res.mem_word;
  assign exfil_valid_o     = res.exfil_valid;
  assign exfil_byte_o      = res.exfil_byte;
  assign mode_now_o        = res.mode_now;
  assign exfil_on_o        = res.exfil_on;
  assign led_on_o          = res.led_on;

endmodule
